### rtl/nibble_block_rotate_macros.svh
// ---------------------------------------------------------------------------
// nibble_block_rotate_macros: assertion helpers
// Shorthand for clocked assertions on clk_i with active-low reset rst_ni.
// ---------------------------------------------------------------------------
`ifndef NIBBLE_BLOCK_ROTATE_MACROS_SVH
`define NIBBLE_BLOCK_ROTATE_MACROS_SVH

// Checked only while out of reset.
`define NBR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define NBR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/nbr_pkg.sv
// ---------------------------------------------------------------------------
// nbr_pkg: shared types and constants
// Widths, bank geometry and control types for the nibble block rotator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package nbr_pkg;

  localparam int WORD_COUNT = 512;
  localparam int WORD_W     = 32;
  localparam int NIB_W      = 4;
  localparam int LANES      = WORD_W / NIB_W;       // nibbles per word, also banks
  localparam int DIG_W      = 3;                    // one octal index digit
  localparam int IDX_W      = 3 * DIG_W;            // 9-bit word index
  localparam int BANK_DEPTH = WORD_COUNT / LANES;   // 64 words per bank
  localparam int BANK_AW    = 2 * DIG_W;

  // request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_RD
  } nbr_state_e;

  typedef struct packed {
    logic wr_en;     // store the request word
    logic rd_en;     // start a gather, latch nibble select
    logic load_out;  // move gathered word into output register
  } nbr_cmd_t;

  typedef struct packed {
    logic req_read;  // pending request is a read
  } nbr_status_t;

endpackage

### rtl/nbr_req_if.sv
// ---------------------------------------------------------------------------
// nbr_req_if: request channel
// Valid/ready channel carrying one write or read request per beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface nbr_req_if
  import nbr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [IDX_W-1:0]  word_index;
  logic [WORD_W-1:0] word_data;

  modport source (output valid, output req_type, output word_index, output word_data,
                  input ready);
  modport sink   (input valid, input req_type, input word_index, input word_data,
                  output ready);
endinterface

### rtl/nbr_rsp_if.sv
// ---------------------------------------------------------------------------
// nbr_rsp_if: response channel
// Valid/ready channel carrying one rearranged word per beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface nbr_rsp_if
  import nbr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] rotated_word;

  modport source (output valid, output rotated_word, input ready);
  modport sink   (input valid, input rotated_word, output ready);
endinterface

### rtl/nbr_ram.sv
// ---------------------------------------------------------------------------
// nbr_ram: generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nbr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/nbr_ctrl.sv
// ---------------------------------------------------------------------------
// nbr_ctrl: request controller
// Sequences writes, bank reads and the output register handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "nibble_block_rotate_macros.svh"

module nbr_ctrl
  import nbr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  output logic        rsp_valid_o,
  input  logic        rsp_ready_i,
  input  nbr_status_t status_i,
  output nbr_cmd_t    cmd_o
);

  nbr_state_e state_q, state_d;
  logic       rsp_valid_q, rsp_valid_d;
  logic       out_free;

  // output slot free now or emptied this edge
  assign out_free = !rsp_valid_q || rsp_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i && status_i.req_read) begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o    = 1'b1;
        cmd_o.wr_en    = req_valid_i && !status_i.req_read;
        cmd_o.rd_en    = req_valid_i && status_i.req_read;
      end
      ST_RD: begin
        cmd_o.load_out = out_free;
      end
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (cmd_o.load_out) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

  `NBR_ASSERT(a_rd_to_rd, cmd_o.rd_en |=> state_q == ST_RD, "read accept did not enter RD")
  `NBR_ASSERT(a_rd_done, (state_q == ST_RD) && out_free |=> (state_q == ST_IDLE) && rsp_valid_q, "gathered word not delivered")
  `NBR_ASSERT(a_rsp_src, $rose(rsp_valid_q) |-> $past(state_q) == ST_RD, "response without gather")
  `NBR_ASSERT_RST(a_rst_quiet, !rst_ni |=> !rsp_valid_q, "response valid right after reset")

endmodule

### rtl/nbr_datapath.sv
// ---------------------------------------------------------------------------
// nbr_datapath: banked store and nibble gather
// Eight banks split by the middle index digit; one read gathers a word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nbr_datapath
  import nbr_pkg::*;
(
  input  logic              clk_i,
  input  nbr_cmd_t          cmd_i,
  output nbr_status_t       status_o,
  input  logic              req_type_i,
  input  logic [IDX_W-1:0]  word_index_i,
  input  logic [WORD_W-1:0] word_data_i,
  output logic [WORD_W-1:0] rotated_word_o
);

  logic [DIG_W-1:0]   dig_lo, dig_mid, dig_hi;
  logic [BANK_AW-1:0] waddr, raddr;
  logic [WORD_W-1:0]  bank_rdata [LANES];
  logic [DIG_W-1:0]   sel_q;           // source nibble, 7-k
  logic [WORD_W-1:0]  gather;
  logic [WORD_W-1:0]  out_q;

  assign status_o.req_read = (req_type_i == REQ_READ);

  assign dig_lo  = word_index_i[DIG_W-1:0];
  assign dig_mid = word_index_i[2*DIG_W-1:DIG_W];
  assign dig_hi  = word_index_i[IDX_W-1:2*DIG_W];

  // store: bank = middle digit, row = {high, low}
  assign waddr = {dig_hi, dig_lo};
  // gather: every bank at row {j, 7-i}
  assign raddr = {dig_lo, ~dig_hi};

  for (genvar b = 0; b < LANES; b++) begin : g_bank
    nbr_ram #(
      .WIDTH(WORD_W),
      .DEPTH(BANK_DEPTH)
    ) u_bank (
      .clk_i  (clk_i),
      .we_i   (cmd_i.wr_en && (dig_mid == DIG_W'(b))),
      .waddr_i(waddr),
      .wdata_i(word_data_i),
      .re_i   (cmd_i.rd_en),
      .raddr_i(raddr),
      .rdata_o(bank_rdata[b])
    );
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      sel_q <= ~dig_mid;
    end
    if (cmd_i.load_out) begin
      out_q <= gather;
    end
  end

  always_comb begin
    for (int m = 0; m < LANES; m++) begin
      gather[m*NIB_W +: NIB_W] = bank_rdata[m][sel_q*NIB_W +: NIB_W];
    end
  end

  assign rotated_word_o = out_q;

endmodule

### rtl/nibble_block_rotate.sv
// ---------------------------------------------------------------------------
// nibble_block_rotate: 4bpp pixel block rotator
// 512-word store of packed 4-bit pixels with a rotated read view.
// ---------------------------------------------------------------------------
// Usage:
//   req_i carries one beat per request. req_type REQ_WRITE stores word_data at
//   word_index; REQ_READ returns one word of the rearranged view on rsp_o.
//   For read index o = i*64 + k*8 + j, nibble m of rotated_word is nibble
//   (7-k) of stored word j*64 + m*8 + (7-i). Writes give no response beat.
//   Timing: the next beat may follow a write at once. A read holds the
//   request side until its word is loaded: the accepting edge reads all
//   eight banks and enters RD, and the first edge in RD with the output slot
//   free loads the gathered word into the output register; rsp_o.valid rises
//   after that edge. The controller drops req_i.ready in RD, so no request is
//   taken while a read is gathering; writes run at one per cycle while idle.
//   Stalls: the output register holds a finished word while rsp_o.ready is
//   low; writes and one further read are still accepted. That read's word
//   waits in the bank read registers, with req_i.ready low, until the slot
//   frees.
//   Reset clears the controller and the response valid; the store contents
//   are undefined until written, and reading an unwritten word is not
//   allowed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nibble_block_rotate
  import nbr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  nbr_req_if.sink  req_i,
  nbr_rsp_if.source rsp_o
);

  nbr_cmd_t    cmd;
  nbr_status_t status;

  // Controller: FSM and response valid
  nbr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_i.valid),
    .req_ready_o(req_i.ready),
    .rsp_valid_o(rsp_o.valid),
    .rsp_ready_i(rsp_o.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: eight banks, nibble gather, output register
  nbr_datapath u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .req_type_i    (req_i.req_type),
    .word_index_i  (req_i.word_index),
    .word_data_i   (req_i.word_data),
    .rotated_word_o(rsp_o.rotated_word)
  );

endmodule
